### sv/btg_pkg.sv
package btg_pkg;

  // Coordinate differences are 33 bits. They are scaled by 2^24 before the CORDIC
  // iterations, and the CORDIC gain adds about 0.7 bit on top of that.
  localparam int DIFF_W = 33;
  localparam int PRE_SHIFT = 24;
  localparam int XY_W = 60;

  // The angle accumulator uses units where pi = 2^31.
  // The worst-case sum of the table plus pi/2 stays below 2^32.
  localparam int Z_W = 34;

  localparam int HEAD_W = 16;
  localparam int OUT_W = 17;

  localparam int ATAN_DEPTH = 32;

  // atan(2^-i) in units where pi = 2^31.
  localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  typedef struct packed {
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [Z_W-1:0]    z;
    logic                     zero;
    logic signed [HEAD_W-1:0] heading;
  } cvec_t;

endpackage

### sv/btg_front.sv
module btg_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  pose_x,
  input  logic signed [31:0]  pose_y,
  input  logic signed [15:0]  heading,
  input  logic signed [31:0]  goal_x,
  input  logic signed [31:0]  goal_y,
  output logic                out_valid,
  input  logic                out_ready,
  output btg_pkg::cvec_t      out_vec
);
  import btg_pkg::*;

  logic                     diff_valid;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [HEAD_W-1:0] diff_heading;
  logic                     diff_ready;
  logic                     rot_ready;

  logic signed [XY_W-1:0] x0;
  logic signed [XY_W-1:0] y0;
  cvec_t                  vec_next;

  assign rot_ready  = !out_valid || out_ready;
  assign diff_ready = !diff_valid || rot_ready;
  assign in_ready   = diff_ready;

  // Stage 1: the goal vector, widened so that it cannot overflow.
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
    end else if (diff_ready) begin
      diff_valid <= in_valid;
    end
    if (diff_ready && in_valid) begin
      dx           <= {goal_x[31], goal_x} - {pose_x[31], pose_x};
      dy           <= {goal_y[31], goal_y} - {pose_y[31], pose_y};
      diff_heading <= heading;
    end
  end

  // Stage 2: scaling, and a quarter turn toward the right half plane when dx is negative.
  assign x0 = XY_W'(dx) <<< PRE_SHIFT;
  assign y0 = XY_W'(dy) <<< PRE_SHIFT;

  always_comb begin
    vec_next.zero    = (dx == '0) && (dy == '0);
    vec_next.heading = diff_heading;
    if (x0[XY_W-1]) begin
      if (!y0[XY_W-1]) begin
        vec_next.x = y0;
        vec_next.y = -x0;
        vec_next.z = Z_W'(1) <<< 30;
      end else begin
        vec_next.x = -y0;
        vec_next.y = x0;
        vec_next.z = -(Z_W'(1) <<< 30);
      end
    end else begin
      vec_next.x = x0;
      vec_next.y = y0;
      vec_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rot_ready) begin
      out_valid <= diff_valid;
    end
    if (rot_ready && diff_valid) begin
      out_vec <= vec_next;
    end
  end

endmodule

### sv/btg_cordic_stage.sv
module btg_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  btg_pkg::cvec_t in_vec,
  output logic           out_valid,
  input  logic           out_ready,
  output btg_pkg::cvec_t out_vec
);
  import btg_pkg::*;

  localparam int K = STEP % ATAN_DEPTH;
  localparam logic signed [Z_W-1:0] ANGLE = Z_W'(ATAN_TAB[K]);

  logic signed [XY_W-1:0] x_sh;
  logic signed [XY_W-1:0] y_sh;
  cvec_t                  vec_next;

  assign in_ready = !out_valid || out_ready;
  assign x_sh = in_vec.x >>> K;
  assign y_sh = in_vec.y >>> K;

  always_comb begin
    vec_next = in_vec;
    if (!in_vec.y[XY_W-1]) begin
      vec_next.x = in_vec.x + y_sh;
      vec_next.y = in_vec.y - x_sh;
      vec_next.z = in_vec.z + ANGLE;
    end else begin
      vec_next.x = in_vec.x - y_sh;
      vec_next.y = in_vec.y + x_sh;
      vec_next.z = in_vec.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_vec <= vec_next;
    end
  end

endmodule

### sv/btg_back.sv
module btg_back #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  btg_pkg::cvec_t       in_vec,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [16:0]   bearing
);
  import btg_pkg::*;

  localparam int S1 = 32 - ANGLE_BITS;
  localparam int SH = ANGLE_BITS - 16;
  localparam logic signed [Z_W-1:0] RND1 = Z_W'(1) <<< (S1 - 1);

  logic                     rnd_valid;
  logic                     rnd_ready;
  logic signed [Z_W-1:0]    z_round;
  logic signed [HEAD_W-1:0] rnd_heading;
  logic signed [Z_W-1:0]    z_in;
  logic signed [Z_W-1:0]    z_scaled;
  logic [15:0]              rel;
  logic signed [OUT_W-1:0]  bearing_next;

  assign in_ready  = !rnd_valid || rnd_ready;
  assign rnd_ready = !out_valid || out_ready;

  // A zero vector has an angle of zero, whatever the iterations left behind.
  assign z_in = in_vec.zero ? '0 : in_vec.z;

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_valid <= 1'b0;
    end else if (in_ready) begin
      rnd_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      z_round     <= (z_in + RND1) >>> S1;
      rnd_heading <= in_vec.heading;
    end
  end

  generate
    if (SH > 0) begin : g_down
      localparam logic signed [Z_W-1:0] RND2 = Z_W'(1) <<< (SH - 1);
      assign z_scaled = (z_round + RND2) >>> SH;
    end else if (SH < 0) begin : g_up
      assign z_scaled = z_round <<< (-SH);
    end else begin : g_same
      assign z_scaled = z_round;
    end
  endgenerate

  // Everything above the low 16 bits drops out in the wrap. A value of -pi is
  // reported as +pi.
  assign rel = z_scaled[15:0] - rnd_heading[15:0];
  assign bearing_next = (rel > 16'h8000) ? {1'b1, rel} : {1'b0, rel};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rnd_ready) begin
      out_valid <= rnd_valid;
    end
    if (rnd_ready && rnd_valid) begin
      bearing <= bearing_next;
    end
  end

endmodule

### sv/bearing_to_goal.sv
// channel  valid      stall      payload
// input    in_valid   in_stall   pose_x, pose_y, heading, goal_x, goal_y
// output   out_valid  out_stall  bearing
//
// One transaction can enter every cycle as long as out_stall is low. The pipe holds
// two front stages (difference, quarter turn), one stage for each CORDIC iteration,
// and two back stages (rounding, heading subtract and wrap).
// Reset clears every stage's valid bit. A stall holds only the stages that are full
// up to the output. Empty stages keep filling, so in_stall rises only when
// the whole pipe is full.
module bearing_to_goal #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  pose_x,
  input  logic signed [31:0]  pose_y,
  input  logic signed [15:0]  heading,
  input  logic signed [31:0]  goal_x,
  input  logic signed [31:0]  goal_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [16:0]  bearing
);
  import btg_pkg::*;

  cvec_t stage_vec   [CORDIC_STEPS+1];
  logic  stage_valid [CORDIC_STEPS+1];
  logic  stage_ready [CORDIC_STEPS+1];
  logic  front_ready;

  assign in_stall = !front_ready;

  btg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (front_ready),
    .pose_x    (pose_x),
    .pose_y    (pose_y),
    .heading   (heading),
    .goal_x    (goal_x),
    .goal_y    (goal_y),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_vec   (stage_vec[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    btg_cordic_stage #(
      .STEP (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_vec    (stage_vec[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_vec   (stage_vec[i+1])
    );
  end

  btg_back #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[CORDIC_STEPS]),
    .in_ready  (stage_ready[CORDIC_STEPS]),
    .in_vec    (stage_vec[CORDIC_STEPS]),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .bearing   (bearing)
  );

endmodule
